// ----- design/assert_macros.svh -----
// assertion macros shared by the encoder rtl
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define B64E_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent holds whenever antecedent holds outside reset
`define B64E_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define B64E_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define B64E_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/b64e_pkg.sv -----
// types, constants and the character map of the base64 encoder
// no dependencies
`default_nettype none
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] PLUS_CHAR  = 7'h2B;
    localparam logic [6:0] SLASH_CHAR = 7'h2F;

    // buffered byte count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;

    // number of padding characters in a group
    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    // char position of the last character in a group
    localparam logic [1:0] POS_LAST = 2'd3;

    localparam int unsigned FIFO_DEPTH = 2;

    // one group of up to three bytes on its way to the output side
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad_count;
        logic        last;
    } group_t;

    // six bit value to its alphabet character
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] ch;
        if (v inside {[6'd0:6'd25]})
            ch = {1'b0, v} + 7'd65;
        else if (v inside {[6'd26:6'd51]})
            ch = {1'b0, v} + 7'd71;
        else if (v inside {[6'd52:6'd61]})
            ch = {1'b0, v} - 7'd4;
        else if (v == 6'd62)
            ch = PLUS_CHAR;
        else
            ch = SLASH_CHAR;
        return ch;
    endfunction

endpackage
`default_nettype wire

// ----- design/b64e_if.sv -----
// valid/ready channel interfaces for the byte input and character output
// no dependencies
`default_nettype none
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       end_of_message;

    modport source (output valid, output out_char, output end_of_message, input ready);
    modport sink   (input valid, input out_char, input end_of_message, output ready);
endinterface
`default_nettype wire

// ----- design/b64e_front.sv -----
// front side: gathers bytes into groups and pushes finished groups to the queue
// depends on b64e_pkg, b64e_if.sv and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module b64e_front
(
    input  logic                clk,
    input  logic                rst_n,
    b64e_byte_if.sink           byte_in,
    input  logic                push_ready,
    output logic                push_valid,
    output b64e_pkg::group_t    push_group
);

    logic [15:0] pend_reg;
    logic [15:0] pend_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        accept;
    logic        emit;

    assign byte_in.ready = push_ready;
    assign accept        = byte_in.valid && byte_in.ready;

    // a group closes on its third byte or on the last byte
    assign emit       = cnt_reg[1] || byte_in.last_byte;
    assign push_valid = accept && emit;

    // group assembly, low bytes zero-filled for a short final group
    always_comb
    begin
        push_group.last = byte_in.last_byte;
        case (cnt_reg)
            b64e_pkg::CNT_NONE:
            begin
                push_group.bits      = {byte_in.data_byte, 16'h0000};
                push_group.pad_count = b64e_pkg::PAD_TWO;
            end
            b64e_pkg::CNT_ONE:
            begin
                push_group.bits      = {pend_reg[7:0], byte_in.data_byte, 8'h00};
                push_group.pad_count = b64e_pkg::PAD_ONE;
            end
            default:
            begin
                push_group.bits      = {pend_reg, byte_in.data_byte};
                push_group.pad_count = b64e_pkg::PAD_NONE;
            end
        endcase
    end

    // pending byte buffer
    always_comb
    begin
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            if (emit)
            begin
                pend_next = 16'h0000;
                cnt_next  = b64e_pkg::CNT_NONE;
            end
            else
            begin
                pend_next = {pend_reg[7:0], byte_in.data_byte};
                cnt_next  = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 16'h0000;
            cnt_reg  <= b64e_pkg::CNT_NONE;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    `B64E_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg != 2'd3, "pending count reached three")
    `B64E_ASSERT_IMPLIES(a_cnt_one_high_clear, clk, rst_n, cnt_reg == b64e_pkg::CNT_ONE,
        pend_reg[15:8] == 8'h00, "stale byte in buffer with one byte pending")

endmodule
`default_nettype wire

// ----- design/b64e_fifo.sv -----
// short group queue between the front and back sides
// depends on b64e_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module b64e_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  b64e_pkg::group_t    push_group,
    output logic                pop_valid,
    input  logic                pop_ready,
    output b64e_pkg::group_t    pop_group
);

    localparam int unsigned PTR_W = $clog2(b64e_pkg::FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(b64e_pkg::FIFO_DEPTH + 1);

    b64e_pkg::group_t   entry_reg [b64e_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(b64e_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_group  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    // pointers wrap at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(b64e_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(b64e_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_group;
    end

    `B64E_ASSERT_ALWAYS(a_count_bound, clk, rst_n,
        count_reg <= CNT_W'(b64e_pkg::FIFO_DEPTH), "queue count above depth")

endmodule
`default_nettype wire

// ----- design/b64e_back.sv -----
// back side: turns each queued group into four characters, one per cycle while the receiver is ready
// depends on b64e_pkg, b64e_if.sv and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module b64e_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  b64e_pkg::group_t    pop_group,
    b64e_char_if.source         char_out
);

    b64e_pkg::group_t   cur_reg;
    logic               cur_valid_reg;
    logic [1:0]         pos_reg;
    logic               out_valid_reg;
    logic [6:0]         out_char_reg;
    logic               out_end_reg;
    logic               advance;
    logic               load;
    logic [5:0]         sextet;
    logic               is_pad;
    logic [6:0]         char_next;
    logic               end_next;

    assign char_out.valid          = out_valid_reg;
    assign char_out.out_char       = out_char_reg;
    assign char_out.end_of_message = out_end_reg;

    // output register frees up when empty or taken
    assign advance   = !out_valid_reg || char_out.ready;
    assign load      = advance && cur_valid_reg;
    assign pop_ready = !cur_valid_reg || (load && pos_reg == b64e_pkg::POS_LAST);

    // character of the current position
    always_comb
    begin
        case (pos_reg)
            2'd0:    sextet = cur_reg.bits[23:18];
            2'd1:    sextet = cur_reg.bits[17:12];
            2'd2:    sextet = cur_reg.bits[11:6];
            default: sextet = cur_reg.bits[5:0];
        endcase
        case (cur_reg.pad_count)
            b64e_pkg::PAD_TWO: is_pad = pos_reg[1];
            b64e_pkg::PAD_ONE: is_pad = pos_reg == b64e_pkg::POS_LAST;
            default:           is_pad = 1'b0;
        endcase
        char_next = is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(sextet);
        end_next  = cur_reg.last && (pos_reg == b64e_pkg::POS_LAST);
    end

    // current group and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else if (pop_valid && pop_ready)
        begin
            cur_valid_reg <= 1'b1;
            pos_reg       <= 2'd0;
        end
        else if (load)
        begin
            pos_reg <= pos_reg + 2'd1;
            if (pos_reg == b64e_pkg::POS_LAST)
                cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            cur_reg <= pop_group;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_next;
            out_end_reg  <= end_next;
        end
    end

    `B64E_ASSERT_IMPLIES(a_idle_pos_zero, clk, rst_n, !cur_valid_reg, pos_reg == 2'd0,
        "position not at group start while idle")
    `B64E_ASSERT_IMPLIES(a_end_on_last_pos, clk, rst_n, load && end_next,
        pos_reg == b64e_pkg::POS_LAST, "end mark off the fourth character")

endmodule
`default_nettype wire

// ----- design/base64_encoder_unit.sv -----
// Streaming base64 encoder, standard alphabet, '=' padding.
// A group's first character passes the queue, the group register and the output register.
// Throughput: one character per cycle from the back side while the receiver is ready; bytes
// are taken one per cycle while the two-entry group queue has room.
// Reset: asynchronous, active low; clears the byte buffer, queue and output valid.
// depends on b64e_pkg, b64e_if.sv, b64e_front, b64e_fifo, b64e_back
`default_nettype none
module base64_encoder_unit
(
    input  logic            clk,
    input  logic            rst_n,
    b64e_byte_if.sink       byte_in,
    b64e_char_if.source     char_out
);

    logic               push_valid;
    logic               push_ready;
    b64e_pkg::group_t   push_group;
    logic               pop_valid;
    logic               pop_ready;
    b64e_pkg::group_t   pop_group;

    // byte gathering
    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_group (push_group)
    );

    // group queue
    b64e_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_group  (pop_group)
    );

    // character output
    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_group  (pop_group),
        .char_out   (char_out)
    );

endmodule
`default_nettype wire
